[hdl/three_wire_rtc_serial_master_assert.svh]
// Assertion macros used by the serial master module.
// Each macro expects a clock named aclk and an active-low reset named aresetn.
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_ASSERT_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWRTC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("twrtc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TWRTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("twrtc assertion failed");

`endif

[hdl/twrtc_pkg.sv]
package twrtc_pkg;

    localparam int BYTE_BITS = 8;
    localparam int HALF_W = 16;
    localparam int BIT_CNT_W = 4;
    localparam logic [BYTE_BITS-1:0] READ_FLAG = 8'h01;
    localparam logic [HALF_W-1:0] HALF_RESET = 16'd200;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT = 4'd15;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SETUP = 2'd1,
        PH_LOW   = 2'd2,
        PH_HIGH  = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t                  phase;
        logic [BIT_CNT_W-1:0]    bit_count;
        logic [HALF_W-1:0]       tick_count;
        logic [2*BYTE_BITS-1:0]  shift_out;
        logic [BYTE_BITS-1:0]    shift_in;
        logic                    is_read;
    } twrtc_state_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] read_data;
        logic                 read_valid;
        logic                 accepted;
        logic                 busy_res;
        logic                 io_drive;
        logic                 io_out;
        logic                 sclk_pin;
        logic                 rst_pin;
    } twrtc_result_t;

endpackage

[hdl/three_wire_rtc_serial_master.sv]
// Channel   Direction  tdata / tuser contents
// s_ (in)   input      tuser: action; tdata: reg_addr, wr_data, io_in
// m_ (out)  output     tdata: pin levels, busy, accepted, read_valid, read_data
// cfg       input      half_period_ticks, written when cfg_we is high
//
// One word is taken per cycle while s_tready is high; every input word yields exactly one output word.
// The transfer state and the output register advance together in the accepting cycle.
// A stalled output word holds s_tready low only until it is taken (m_tready).
// Reset (aresetn low, synchronous) returns to idle with a half period of 200 ticks.
module three_wire_rtc_serial_master (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] reg_addr, [15:8] wr_data, [16] io_in, [23:17] zero
    input  logic [23:0] s_tdata,
    // [1:0] action
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] rst_pin, [1] sclk_pin, [2] io_out, [3] io_drive, [4] busy_res,
    // [5] accepted, [6] read_valid, [14:7] read_data, [15] zero
    output logic [15:0] m_tdata
);
    import twrtc_pkg::*;

    `include "three_wire_rtc_serial_master_assert.svh"

    logic [HALF_W-1:0] half_reg;
    twrtc_state_t      state_reg;
    twrtc_state_t      state_next;
    twrtc_result_t     out_reg;
    twrtc_result_t     out_next;
    logic              m_valid_reg;
    logic              s_fire;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    twrtc_step u_step (
        .state_i      (state_reg),
        .action_i     (s_tuser),
        .reg_addr_i   (s_tdata[7:0]),
        .wr_data_i    (s_tdata[15:8]),
        .io_in_i      (s_tdata[16]),
        .half_ticks_i (half_reg),
        .state_o      (state_next),
        .result_o     (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg <= HALF_RESET;
        end else if (cfg_we) begin
            half_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '{phase: PH_IDLE, default: '0};
            out_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            state_reg   <= state_next;
            out_reg     <= out_next;
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_reg.read_data, out_reg.read_valid, out_reg.accepted,
                       out_reg.busy_res, out_reg.io_drive, out_reg.io_out,
                       out_reg.sclk_pin, out_reg.rst_pin};

    // The final tick of a transfer is still a high clock half.
    `TWRTC_ASSERT_SAME(a_idle_counters_clear, state_reg.phase == PH_IDLE,
        state_reg.bit_count == '0 && state_reg.tick_count == '0)
    `TWRTC_ASSERT_SAME(a_accept_drives_pins, out_reg.accepted,
        out_reg.busy_res && out_reg.rst_pin && out_reg.io_drive && !out_reg.sclk_pin)
    `TWRTC_ASSERT_SAME(a_read_done_is_idle, out_reg.read_valid,
        state_reg.phase == PH_IDLE && out_reg.sclk_pin)
    `TWRTC_ASSERT_NEXT(a_read_sets_flag,
        s_fire && state_reg.phase == PH_IDLE && s_tuser == ACT_READ,
        state_reg.is_read && state_reg.shift_out[0])

endmodule

[hdl/twrtc_step.sv]
module twrtc_step (
    input  twrtc_pkg::twrtc_state_t  state_i,
    input  logic [1:0]               action_i,
    input  logic [7:0]               reg_addr_i,
    input  logic [7:0]               wr_data_i,
    input  logic                     io_in_i,
    input  logic [15:0]              half_ticks_i,
    output twrtc_pkg::twrtc_state_t  state_o,
    output twrtc_pkg::twrtc_result_t result_o
);
    import twrtc_pkg::*;

    twrtc_state_t  cur;
    twrtc_state_t  nxt;
    twrtc_result_t res;
    logic [HALF_W-1:0] half;
    logic              rx;
    logic              half_done;

    always_comb begin
        half = (half_ticks_i == '0) ? HALF_W'(1) : half_ticks_i;
        cur = state_i;
        res = '0;

        // A command is only taken between transfers.
        if (cur.phase == PH_IDLE &&
            (action_i == ACT_WRITE || action_i == ACT_READ)) begin
            cur.is_read    = (action_i == ACT_READ);
            cur.shift_out  = cur.is_read ? {8'h00, reg_addr_i | READ_FLAG}
                                         : {wr_data_i, reg_addr_i};
            cur.shift_in   = '0;
            cur.bit_count  = '0;
            cur.tick_count = '0;
            cur.phase      = PH_SETUP;
            res.accepted   = 1'b1;
        end

        nxt = cur;
        rx = cur.is_read && cur.bit_count[3];
        half_done = ({1'b0, cur.tick_count} + 17'd1) >= {1'b0, half};

        if (cur.phase != PH_IDLE) begin
            res.rst_pin  = 1'b1;
            res.busy_res = 1'b1;
            res.sclk_pin = (cur.phase == PH_HIGH);
            if (cur.phase == PH_SETUP) begin
                res.io_drive = 1'b1;
            end else if (!rx) begin
                res.io_drive = 1'b1;
                res.io_out   = cur.shift_out[cur.bit_count];
            end

            if (half_done) begin
                nxt.tick_count = '0;
                unique case (cur.phase)
                    PH_SETUP: nxt.phase = PH_LOW;
                    PH_LOW: begin
                        // Sample on the last tick before the clock rises.
                        if (rx) begin
                            nxt.shift_in = cur.shift_in |
                                (BYTE_BITS'(io_in_i) << cur.bit_count[2:0]);
                        end
                        nxt.phase = PH_HIGH;
                    end
                    PH_HIGH: begin
                        if (cur.bit_count == LAST_BIT) begin
                            nxt.bit_count  = '0;
                            nxt.phase      = PH_IDLE;
                            res.read_valid = cur.is_read;
                            res.read_data  = cur.is_read ? cur.shift_in : '0;
                        end else begin
                            nxt.bit_count = cur.bit_count + BIT_CNT_W'(1);
                            nxt.phase     = PH_LOW;
                        end
                    end
                    default: nxt.phase = cur.phase;
                endcase
            end else begin
                nxt.tick_count = cur.tick_count + HALF_W'(1);
            end
        end

        state_o  = nxt;
        result_o = res;
    end

endmodule
